@@ src/tsat_pkg.sv @@
package tsat_pkg;

	localparam int VAR_W = 11;
	localparam int NUM_VARS_W = 11;
	localparam logic [NUM_VARS_W-1:0] NUM_VARS_RST = 11'd1024;
	localparam int IN_DATA_W = 24;
	localparam int OUT_DATA_W = 8;

endpackage

@@ src/two_sat_scc_checker.sv @@
// 2-SAT checker built on Kosaraju strongly connected components.
// Each slave transaction carries one 2-CNF clause. Both implication edges of
// the clause go into the clause store as one word, one clause per cycle while idle.
// The transaction with tlast starts the solve. s_tready then stays low while:
//   - the node store is cleared, all 2n entries (n = effective num_vars),
//   - pass 1 runs a depth-first walk over the reversed graph from every node,
//     logging finish order,
//   - pass 2 walks the forward graph from nodes in reverse finish order and
//     flags a node whose complement lands in the same component.
// Each walk step scans the clause store linearly from the resume index of the
// stack top: each edge examined is read (ST_SCAN_RD) and checked (ST_SCAN_CHK);
// an edge that points at the node also has its candidate checked (ST_CAND_CHK,
// then ST_COMP_CHK in pass 2 when it leads to a node not yet seen), and a pop
// reloads the stack top (ST_POP_WAIT). The clause store has a single read port.
// The verdict lands in an output register; new clauses are taken while it
// waits. A variable of 0 or above n, or a clause beyond the store, sets
// bad_input; such a clause is dropped. After the verdict the formula is cleared.
// num_vars is to be written only while the block is idle (the block itself does
// not enforce this); values above MAX_VARS act as MAX_VARS.
module two_sat_scc_checker
	import tsat_pkg::*;
#(
	parameter int MAX_VARS    = 1024,
	parameter int MAX_CLAUSES = 4096
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// [10:0] first_var, [11] first_negated, [22:12] second_var, [23] second_negated
	input  logic [IN_DATA_W-1:0]    s_tdata,
	input  logic                    s_tlast,   // last_clause
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// [0] satisfiable, [1] bad_input, rest zero
	output logic [OUT_DATA_W-1:0]   m_tdata,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [NUM_VARS_W-1:0]   cfg_data   // num_vars
);

	localparam int NODE_CAP = 2 * MAX_VARS;
	localparam int NW  = $clog2(NODE_CAP);
	localparam int CW  = NW + 1;
	localparam int AW  = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
	localparam int CCW = $clog2(MAX_CLAUSES + 1);
	localparam int EW  = CCW + 1;

	typedef struct packed {
		logic [CW-1:0] comp;
		logic          vf;
		logic          vr;
	} node_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLR, ST_P1_RD, ST_P1_CHK, ST_SCAN_RD, ST_SCAN_CHK,
		ST_CAND_CHK, ST_COMP_CHK, ST_POP_WAIT, ST_P2_RD, ST_P2_F, ST_P2_CHK,
		ST_DONE
	} state_t;

	function automatic logic [NW-1:0] compl_node(input logic [NW-1:0] x,
		input logic [NW-1:0] nn);
		return (x < nn) ? x + nn : x - nn;
	endfunction

	state_t              state_q;
	logic [NUM_VARS_W-1:0] num_vars_q;
	logic [CCW-1:0]      cc_q;
	logic                err_q;
	logic [NW-1:0]       n_q;
	logic [NW:0]         nodes_q, i_q, j_q, fcnt_q, dep_q;
	logic [NW-1:0]       u_q, v_q;
	logic [EW-1:0]       e_q;
	node_t               vdata_q;
	logic [CW-1:0]       cur_q;
	logic                sat_q, pass2_q;
	logic                ovalid_q, osat_q, obad_q;

	// config and ingest
	logic [NW-1:0]    n_eff;
	logic [NW:0]      nodes_eff;
	logic [VAR_W-1:0] v1, v2;
	logic             ng1, ng2, in_acc, bad_var, full, store;
	logic [NW-1:0]    lit1, lit2, neg1, neg2;

	assign cfg_ready = 1'b1;
	assign n_eff     = (32'(num_vars_q) > MAX_VARS) ? NW'(MAX_VARS) : NW'(num_vars_q);
	assign nodes_eff = {n_eff, 1'b0};
	assign v1  = s_tdata[10:0];
	assign ng1 = s_tdata[11];
	assign v2  = s_tdata[22:12];
	assign ng2 = s_tdata[23];
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign bad_var  = (v1 == '0) || (32'(v1) > 32'(n_eff))
		|| (v2 == '0) || (32'(v2) > 32'(n_eff));
	assign full  = (32'(cc_q) >= MAX_CLAUSES);
	assign store = in_acc && !bad_var && !full;
	assign lit1  = NW'(v1 - 1'b1) + (ng1 ? n_eff : '0);
	assign lit2  = NW'(v2 - 1'b1) + (ng2 ? n_eff : '0);
	assign neg1  = compl_node(lit1, n_eff);
	assign neg2  = compl_node(lit2, n_eff);

	// clause store: {dst2, src2, dst1, src1}
	logic [4*NW-1:0] edge_mem [MAX_CLAUSES];
	logic [4*NW-1:0] em_rd;
	logic [AW-1:0]   em_ra;

	always_ff @(posedge clk) begin
		if (store) begin
			edge_mem[AW'(cc_q)] <= {lit1, neg2, lit2, neg1};
		end
		em_rd <= edge_mem[em_ra];
	end

	// node store, walk stack, finish log
	node_t           node_mem [NODE_CAP];
	node_t           nm_rd, nm_wd;
	logic [NW-1:0]   nm_ra, nm_wa;
	logic            nm_we;
	logic [NW+EW-1:0] stk_mem [NODE_CAP];
	logic [NW+EW-1:0] stk_rd, stk_wd;
	logic [NW-1:0]   stk_ra, stk_wa;
	logic            stk_we;
	logic [NW-1:0]   fo_mem [NODE_CAP];
	logic [NW-1:0]   fo_rd, fo_wd, fo_ra, fo_wa;
	logic            fo_we;

	always_ff @(posedge clk) begin
		if (nm_we) begin
			node_mem[nm_wa] <= nm_wd;
		end
		nm_rd <= node_mem[nm_ra];
		if (stk_we) begin
			stk_mem[stk_wa] <= stk_wd;
		end
		stk_rd <= stk_mem[stk_ra];
		if (fo_we) begin
			fo_mem[fo_wa] <= fo_wd;
		end
		fo_rd <= fo_mem[fo_ra];
	end

	// edge decode for the scan
	logic [EW-1:0] ecnt;
	logic [NW-1:0] ea, eb, cand;
	logic          in_rng, hit, cand_vis, scan_end;

	assign ecnt     = {cc_q, 1'b0};
	assign ea       = e_q[0] ? em_rd[3*NW-1:2*NW] : em_rd[NW-1:0];
	assign eb       = e_q[0] ? em_rd[4*NW-1:3*NW] : em_rd[2*NW-1:NW];
	assign in_rng   = ({1'b0, ea} < nodes_q) && ({1'b0, eb} < nodes_q);
	assign cand     = pass2_q ? eb : ea;
	assign hit      = in_rng && (pass2_q ? (ea == u_q) : (eb == u_q));
	assign cand_vis = pass2_q ? nm_rd.vf : nm_rd.vr;
	assign scan_end = (e_q == ecnt);

	always_comb begin
		nm_we  = 1'b0;
		nm_wa  = v_q;
		nm_wd  = vdata_q;
		nm_ra  = v_q;
		em_ra  = AW'(e_q >> 1);
		stk_we = 1'b0;
		stk_wa = NW'(dep_q - 1'b1);
		stk_wd = {u_q, e_q + 1'b1};
		stk_ra = NW'(dep_q - 2'd2);
		fo_we  = 1'b0;
		fo_wa  = NW'(fcnt_q);
		fo_wd  = u_q;
		fo_ra  = NW'(j_q - 1'b1);
		unique case (state_q)
			ST_CLR: begin
				nm_we = 1'b1;
				nm_wa = NW'(i_q);
				nm_wd = '0;
			end
			ST_P1_RD: begin
				nm_ra = NW'(i_q);
			end
			ST_P1_CHK: begin
				if (!nm_rd.vr) begin
					nm_we = 1'b1;
					nm_wd = nm_rd;
					nm_wd.vr = 1'b1;
				end
			end
			ST_SCAN_RD: begin
				if (scan_end && !pass2_q) begin
					fo_we = 1'b1;
				end
			end
			ST_SCAN_CHK: begin
				nm_ra = cand;
			end
			ST_CAND_CHK: begin
				if (!cand_vis) begin
					if (!pass2_q) begin
						nm_we = 1'b1;
						nm_wd = nm_rd;
						nm_wd.vr = 1'b1;
						stk_we = 1'b1;
					end else begin
						nm_ra = compl_node(v_q, n_q);
					end
				end
			end
			ST_COMP_CHK: begin
				nm_we = 1'b1;
				nm_wd = '{comp: cur_q, vf: 1'b1, vr: vdata_q.vr};
				stk_we = (dep_q != '0);
			end
			ST_P2_F: begin
				nm_ra = fo_rd;
			end
			ST_P2_CHK: begin
				nm_ra = compl_node(v_q, n_q);
			end
			ST_IDLE, ST_POP_WAIT, ST_P2_RD, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			num_vars_q <= NUM_VARS_RST;
			cc_q       <= '0;
			err_q      <= 1'b0;
			n_q        <= '0;
			nodes_q    <= '0;
			i_q        <= '0;
			j_q        <= '0;
			fcnt_q     <= '0;
			dep_q      <= '0;
			u_q        <= '0;
			v_q        <= '0;
			e_q        <= '0;
			vdata_q    <= '0;
			cur_q      <= '0;
			sat_q      <= 1'b1;
			pass2_q    <= 1'b0;
			ovalid_q   <= 1'b0;
			osat_q     <= 1'b0;
			obad_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				num_vars_q <= cfg_data;
			end
			if (m_tvalid && m_tready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (store) begin
							cc_q <= cc_q + 1'b1;
						end
						if (bad_var || full) begin
							err_q <= 1'b1;
						end
						if (s_tlast) begin
							n_q     <= n_eff;
							nodes_q <= nodes_eff;
							i_q     <= '0;
							fcnt_q  <= '0;
							cur_q   <= '0;
							dep_q   <= '0;
							sat_q   <= 1'b1;
							pass2_q <= 1'b0;
							state_q <= (nodes_eff == '0) ? ST_DONE : ST_CLR;
						end
					end
				end
				ST_CLR: begin
					if (i_q == nodes_q - 1'b1) begin
						i_q     <= '0;
						state_q <= ST_P1_RD;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_P1_RD: begin
					if (i_q == nodes_q) begin
						pass2_q <= 1'b1;
						j_q     <= fcnt_q;
						state_q <= ST_P2_RD;
					end else begin
						v_q     <= NW'(i_q);
						state_q <= ST_P1_CHK;
					end
				end
				ST_P1_CHK: begin
					if (nm_rd.vr) begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_P1_RD;
					end else begin
						u_q     <= v_q;
						e_q     <= '0;
						dep_q   <= (NW+1)'(1);
						state_q <= ST_SCAN_RD;
					end
				end
				ST_SCAN_RD: begin
					if (scan_end) begin
						// node finished: pop
						if (!pass2_q) begin
							fcnt_q <= fcnt_q + 1'b1;
						end
						dep_q <= dep_q - 1'b1;
						if (dep_q == 1) begin
							if (pass2_q) begin
								j_q     <= j_q - 1'b1;
								state_q <= ST_P2_RD;
							end else begin
								i_q     <= i_q + 1'b1;
								state_q <= ST_P1_RD;
							end
						end else begin
							state_q <= ST_POP_WAIT;
						end
					end else begin
						state_q <= ST_SCAN_CHK;
					end
				end
				ST_POP_WAIT: begin
					{u_q, e_q} <= stk_rd;
					state_q    <= ST_SCAN_RD;
				end
				ST_SCAN_CHK: begin
					if (hit) begin
						v_q     <= cand;
						state_q <= ST_CAND_CHK;
					end else begin
						e_q     <= e_q + 1'b1;
						state_q <= ST_SCAN_RD;
					end
				end
				ST_CAND_CHK: begin
					if (cand_vis) begin
						e_q     <= e_q + 1'b1;
						state_q <= ST_SCAN_RD;
					end else if (!pass2_q) begin
						u_q     <= v_q;
						e_q     <= '0;
						dep_q   <= dep_q + 1'b1;
						state_q <= ST_SCAN_RD;
					end else begin
						vdata_q <= nm_rd;
						state_q <= ST_COMP_CHK;
					end
				end
				ST_COMP_CHK: begin
					// complement already in this component
					if (nm_rd.comp == cur_q) begin
						sat_q <= 1'b0;
					end
					u_q     <= v_q;
					e_q     <= '0;
					dep_q   <= dep_q + 1'b1;
					state_q <= ST_SCAN_RD;
				end
				ST_P2_RD: begin
					state_q <= (j_q == '0) ? ST_DONE : ST_P2_F;
				end
				ST_P2_F: begin
					if ({1'b0, fo_rd} >= nodes_q) begin
						j_q     <= j_q - 1'b1;
						state_q <= ST_P2_RD;
					end else begin
						v_q     <= fo_rd;
						state_q <= ST_P2_CHK;
					end
				end
				ST_P2_CHK: begin
					if (nm_rd.vf) begin
						j_q     <= j_q - 1'b1;
						state_q <= ST_P2_RD;
					end else begin
						vdata_q <= nm_rd;
						cur_q   <= cur_q + 1'b1;
						state_q <= ST_COMP_CHK;
					end
				end
				ST_DONE: begin
					if (!ovalid_q) begin
						ovalid_q <= 1'b1;
						osat_q   <= sat_q;
						obad_q   <= err_q;
						cc_q     <= '0;
						err_q    <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {{(OUT_DATA_W-2){1'b0}}, obad_q, osat_q};

endmodule

@@ src/tsat_chk.sv @@
module tsat_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       s_tlast,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       cfg_ready
);

	// solve starts right after the last clause
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input not stalled after last clause");

	// a verdict only comes out of a solve
	a_verdict_after_solve: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("verdict without solve");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled verdict changed");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind two_sat_scc_checker tsat_chk u_tsat_chk (.*);

@@ tb/sv/tb_two_sat_scc_checker.sv @@
`timescale 1ns / 1ps

module tb_two_sat_scc_checker;
	import tsat_pkg::*;

	localparam int NODE_CAP   = 2 * 1024;
	localparam int EDGE_CAP   = 2 * 4096;
	localparam int IDLE_WAIT  = 32;    // cycles let pass before a num_vars write
	localparam int LONG_HOLD  = 3000;  // receiver hold-off, in cycles

	// one 2-CNF clause as it sits in the sender queue
	typedef struct packed {
		logic [VAR_W-1:0] v1;
		logic             neg1;
		logic [VAR_W-1:0] v2;
		logic             neg2;
		logic             last;
	} clause_t;

	typedef struct packed {
		logic sat;
		logic bad;
	} verdict_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [NUM_VARS_W-1:0] cfg_data = '0;

	two_sat_scc_checker uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	clause_t  clause_q[$];     // clauses waiting to be offered
	verdict_t verdict_q[$];    // verdicts the block still owes
	int       mismatches = 0;
	bit       long_hold_req = 1'b0;
	bit       sender_burst = 1'b0;  // no gaps while set

	// ---- predictor state: mirrors the block's clause store and solver ----
	int unsigned num_vars_reg = 1024;
	int          imp_src[EDGE_CAP];
	int          imp_dst[EDGE_CAP];
	int          imp_cnt = 0;
	bit          bad_seen = 1'b0;
	bit          seen_mark[NODE_CAP];
	bit          comp_mark[NODE_CAP];
	int          fin_order[NODE_CAP];
	int          fin_cnt;
	int          stk_node[NODE_CAP];
	int          stk_edge[NODE_CAP];

	function automatic int eff_vars();
		return (num_vars_reg > 1024) ? 1024 : int'(num_vars_reg);
	endfunction

	// Depth-first walk from start. Reverse graph: log finish order.
	// Forward graph: mark the component, report a complement inside it.
	function automatic bit scc_walk(int start, int nodes, int n, bit rev);
		int sp, v, u, e, top, cmp;
		bit ok, found;
		ok = 1'b1;
		sp = 0;
		v = start;
		forever begin
			seen_mark[v] = 1'b1;
			if (!rev) begin
				cmp = (v < n) ? v + n : v - n;
				if (comp_mark[cmp]) ok = 1'b0;
				comp_mark[v] = 1'b1;
			end
			stk_node[sp] = v;
			stk_edge[sp] = 0;
			sp++;
			found = 1'b0;
			while (!found) begin
				if (sp == 0) return ok;
				top = sp - 1;
				u = stk_node[top];
				for (e = stk_edge[top]; e < imp_cnt; e++) begin
					if (imp_src[e] >= nodes || imp_dst[e] >= nodes) continue;
					if (rev && imp_dst[e] == u && !seen_mark[imp_src[e]]) begin
						v = imp_src[e];
						found = 1'b1;
						break;
					end
					if (!rev && imp_src[e] == u && !seen_mark[imp_dst[e]]) begin
						v = imp_dst[e];
						found = 1'b1;
						break;
					end
				end
				if (found) begin
					stk_edge[top] = e + 1;
				end else begin
					sp--;
					if (rev && fin_cnt < NODE_CAP) begin
						fin_order[fin_cnt] = u;
						fin_cnt++;
					end
				end
			end
		end
	endfunction

	function automatic bit kosaraju_sat();
		int n, nodes, s;
		bit sat;
		n = eff_vars();
		nodes = 2 * n;
		sat = 1'b1;
		foreach (seen_mark[i]) seen_mark[i] = 1'b0;
		fin_cnt = 0;
		for (int i = 0; i < nodes; i++)
			if (!seen_mark[i]) void'(scc_walk(i, nodes, n, 1'b1));
		foreach (seen_mark[i]) seen_mark[i] = 1'b0;
		for (int i = fin_cnt; i > 0; i--) begin
			s = fin_order[i-1];
			if (s < nodes && !seen_mark[s]) begin
				foreach (comp_mark[k]) comp_mark[k] = 1'b0;
				if (!scc_walk(s, nodes, n, 1'b0)) sat = 1'b0;
			end
		end
		return sat;
	endfunction

	// Store one accepted clause; on the last one queue the verdict and clear.
	function automatic void take_clause(clause_t c);
		int n, lit1, lit2;
		verdict_t vd;
		n = eff_vars();
		if (c.v1 == 0 || c.v1 > n || c.v2 == 0 || c.v2 > n) begin
			bad_seen = 1'b1;
		end else if (imp_cnt + 2 > EDGE_CAP) begin
			bad_seen = 1'b1;
		end else begin
			lit1 = int'(c.v1) - 1 + (c.neg1 ? n : 0);
			lit2 = int'(c.v2) - 1 + (c.neg2 ? n : 0);
			imp_src[imp_cnt]   = (lit1 < n) ? lit1 + n : lit1 - n;
			imp_dst[imp_cnt]   = lit2;
			imp_src[imp_cnt+1] = (lit2 < n) ? lit2 + n : lit2 - n;
			imp_dst[imp_cnt+1] = lit1;
			imp_cnt += 2;
		end
		if (c.last) begin
			vd.sat = kosaraju_sat();
			vd.bad = bad_seen;
			verdict_q = {verdict_q, vd};
			imp_cnt = 0;
			bad_seen = 1'b0;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// ---- sender: offers queued clauses, holds them until accepted ----
	int       s_gap = 0;
	clause_t  s_item;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_gap = 0;
		end else begin
			if (s_tvalid && s_tready) take_clause(s_item);
			if (s_tvalid && !s_tready) begin
				// transaction still pending; keep everything stable
			end else if (s_gap > 0) begin
				s_gap--;
				s_tvalid <= 1'b0;
			end else if (clause_q.size() > 0) begin
				s_item = clause_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {s_item.neg2, s_item.v2, s_item.neg1, s_item.v1};
				s_tlast <= s_item.last;
				if ($urandom_range(0, 149) == 0) sender_burst = ~sender_burst;
				s_gap = sender_burst ? 0 : pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ---- receiver ready: random gaps, plus one long hold-off on request ----
	int r_stall = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			r_stall = 0;
		end else if (r_stall > 0) begin
			r_stall--;
			m_tready <= 1'b0;
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			r_stall = LONG_HOLD;
			m_tready <= 1'b0;
		end else begin
			r_stall = pick_gap();
			m_tready <= (r_stall == 0);
		end
	end

	// ---- verdict checker ----
	verdict_t got, want;
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.sat = m_tdata[0];
			got.bad = m_tdata[1];
			if (verdict_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected verdict transaction sat=%0b bad=%0b",
						got.sat, got.bad);
			end else begin
				want = verdict_q.pop_front();
				if (got.sat !== want.sat || got.bad !== want.bad ||
				    m_tdata[OUT_DATA_W-1:2] !== '0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("verdict mismatch: exp sat=%0b bad=%0b, got tdata=%h",
							want.sat, want.bad, m_tdata);
				end
			end
		end
	end

	// ---- stimulus helpers ----
	task automatic add_clause(int v1, bit n1, int v2, bit n2, bit last);
		clause_t c;
		c.v1 = v1[VAR_W-1:0];
		c.neg1 = n1;
		c.v2 = v2[VAR_W-1:0];
		c.neg2 = n2;
		c.last = last;
		clause_q = {clause_q, c};
	endtask

	// sender drained and no verdict owed; this is also the sender pause
	task automatic wait_quiet();
		do @(posedge clk);
		while (clause_q.size() != 0 || s_tvalid || verdict_q.size() != 0);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic write_num_vars(int value);
		wait_quiet();
		cfg_valid <= 1'b1;
		cfg_data <= value[NUM_VARS_W-1:0];
		do @(posedge clk);
		while (!cfg_ready);
		num_vars_reg = value & 32'h7FF;
		cfg_valid <= 1'b0;
	endtask

	function automatic int pick_var(int n);
		if (n >= 1 && $urandom_range(0, 99) < 95) return $urandom_range(1, n);
		if (n >= 2047 || $urandom_range(0, 2) == 0) return 0;
		return $urandom_range(n + 1, 2047);
	endfunction

	task automatic random_formula(int n, int clauses);
		for (int i = 0; i < clauses; i++)
			add_clause(pick_var(n), 1'($urandom_range(0, 1)), pick_var(n),
				1'($urandom_range(0, 1)), i == clauses - 1);
	endtask

	// ---- test sequence ----
	int sent;
	int n_cur;
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset value of num_vars, top and bottom variable numbers
		add_clause(1, 0, 2, 1, 0);
		add_clause(1024, 1, 1024, 0, 1);
		// single variable forced both ways: unsatisfiable
		write_num_vars(1);
		add_clause(1, 0, 1, 0, 0);
		add_clause(1, 1, 1, 1, 1);
		// variable 0 and an out-of-range variable: flagged, clause dropped
		add_clause(0, 0, 1, 0, 0);
		add_clause(1, 0, 2047, 1, 1);
		// zero variables: every clause rejected, verdict satisfiable
		write_num_vars(0);
		add_clause(1, 0, 1, 1, 1);
		// register above the maximum acts as 1024
		write_num_vars(2047);
		add_clause(1024, 0, 1023, 1, 0);
		add_clause(1024, 1, 1023, 0, 1);
		// register changed mid-formula: edges that touch high nodes are dropped
		write_num_vars(8);
		add_clause(7, 0, 8, 0, 0);
		add_clause(8, 1, 8, 1, 0);
		add_clause(1, 0, 2, 0, 0);
		write_num_vars(3);
		add_clause(1, 1, 2, 1, 1);

		// receiver holds off while several formulas pile up behind it
		wait_quiet();
		long_hold_req <= 1'b1;
		for (int f = 0; f < 6; f++) random_formula(3, $urandom_range(1, 6));

		// random formulas, mostly few variables so conflicts are common
		write_num_vars(4);
		n_cur = 4;
		sent = 0;
		while (sent < 1220) begin
			int k;
			if ($urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 9))
					0: n_cur = 1;
					1: n_cur = $urandom_range(16, 64);
					2: n_cur = 1024;
					default: n_cur = $urandom_range(2, 10);
				endcase
				write_num_vars(n_cur);
			end
			k = (n_cur == 1024) ? $urandom_range(1, 4) : $urandom_range(1, 24);
			random_formula(n_cur, k);
			sent += k;
		end

		wait_quiet();
		repeat (64) @(posedge clk);
		if (mismatches == 0)
			$display("[two_sat_scc_checker] OK");
		else
			$display("[two_sat_scc_checker] ERROR");
		$finish;
	end

	initial begin
		#200ms;
		$display("[two_sat_scc_checker] ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
src/tsat_pkg.sv
src/two_sat_scc_checker.sv
src/tsat_chk.sv
tb/sv/tb_two_sat_scc_checker.sv
